// ===== design/pfba_pkg.sv =====
`default_nettype none
package pfba_pkg;

  localparam int unsigned FRAMES      = 4096;
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned WORDS       = FRAMES / WORD_BITS;
  localparam int unsigned WORD_AW     = $clog2(WORDS);
  localparam int unsigned BIT_AW      = $clog2(WORD_BITS);
  localparam int unsigned FRAME_AW    = WORD_AW + BIT_AW;
  localparam int unsigned LIMIT_W     = FRAME_AW + 1;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CFG_W       = LIMIT_W;

  localparam logic [FRAME_AW-1:0] FIRST_FRAME_RST = FRAME_AW'(256);
  localparam logic [LIMIT_W-1:0]  FRAME_LIMIT_RST = LIMIT_W'(FRAMES);

  // register indexes
  localparam logic CFG_FIRST_FRAME = 1'b0;
  localparam logic CFG_FRAME_LIMIT = 1'b1;

  // opcodes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] frame_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] alloc_address;
  } res_t;

  typedef struct packed {
    logic [FRAME_AW-1:0] first_frame;
    logic [LIMIT_W-1:0]  frame_limit;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/pfba_ram.sv =====
`default_nettype none
module pfba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/pfba_ctrl.sv =====
`default_nettype none
module pfba_ctrl (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pfba_pkg::cfg_t                      cfg_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire pfba_pkg::req_t                      in_req_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output pfba_pkg::res_t                           out_res_o,
  output logic                                     ram_we_o,
  output logic [pfba_pkg::WORD_AW-1:0]             ram_waddr_o,
  output logic [pfba_pkg::WORD_BITS-1:0]           ram_wdata_o,
  output logic [pfba_pkg::WORD_AW-1:0]             ram_raddr_o,
  input  wire logic [pfba_pkg::WORD_BITS-1:0]      ram_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_HOLD
  } state_e;

  state_e                             state_q, state_d;
  logic                               out_valid_q, out_valid_d;
  pfba_pkg::res_t                     out_q, out_d;
  pfba_pkg::res_t                     res_q, res_d;
  logic [pfba_pkg::WORD_AW-1:0]       w_q, w_d;
  logic [pfba_pkg::BIT_AW-1:0]        bit_q, bit_d;
  logic [1:0]                         op_q, op_d;
  logic [pfba_pkg::WORDS-1:0]         vld_q, vld_d;

  logic [pfba_pkg::LIMIT_W-1:0]       stop;
  logic [pfba_pkg::LIMIT_W-1:0]       stop_m1;
  logic                               start_ok;
  logic [pfba_pkg::WORD_BITS-1:0]     word;
  logic [pfba_pkg::WORD_BITS-1:0]     mask_lo, mask_hi, cand;
  logic                               found;
  logic [pfba_pkg::BIT_AW-1:0]        found_bit;
  logic [pfba_pkg::WORD_BITS-1:0]     bit_mask;
  logic [pfba_pkg::WORD_AW-1:0]       idle_addr;
  logic                               in_range;
  logic                               out_take;
  logic                               fin;
  pfba_pkg::res_t                     fin_res;

  // scan window: [first_frame, min(frame_limit, FRAMES))
  assign stop     = (cfg_i.frame_limit > pfba_pkg::LIMIT_W'(pfba_pkg::FRAMES)) ?
                    pfba_pkg::LIMIT_W'(pfba_pkg::FRAMES) : cfg_i.frame_limit;
  assign stop_m1  = stop - pfba_pkg::LIMIT_W'(1);
  assign start_ok = {1'b0, cfg_i.first_frame} < stop;

  // words never written since reset read as all free
  assign word = vld_q[w_q] ? ram_rdata_i : '0;

  assign mask_lo = (w_q == cfg_i.first_frame[pfba_pkg::FRAME_AW-1:pfba_pkg::BIT_AW]) ?
                   ({pfba_pkg::WORD_BITS{1'b1}} << cfg_i.first_frame[pfba_pkg::BIT_AW-1:0]) :
                   {pfba_pkg::WORD_BITS{1'b1}};
  assign mask_hi = (w_q == stop_m1[pfba_pkg::FRAME_AW-1:pfba_pkg::BIT_AW]) ?
                   ({pfba_pkg::WORD_BITS{1'b1}} >>
                    (pfba_pkg::BIT_AW'(pfba_pkg::WORD_BITS - 1) -
                     stop_m1[pfba_pkg::BIT_AW-1:0])) :
                   {pfba_pkg::WORD_BITS{1'b1}};
  assign cand    = ~word & mask_lo & mask_hi;
  assign found   = |cand;

  always_comb begin
    found_bit = '0;
    for (int b = pfba_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        found_bit = pfba_pkg::BIT_AW'(b);
      end
    end
  end

  assign bit_mask  = pfba_pkg::WORD_BITS'(1) << ((state_q == S_SCAN) ? found_bit : bit_q);
  assign idle_addr = (in_req_i.opcode == pfba_pkg::OP_ALLOC) ?
                     cfg_i.first_frame[pfba_pkg::FRAME_AW-1:pfba_pkg::BIT_AW] :
                     in_req_i.frame_address[pfba_pkg::FRAME_SHIFT+pfba_pkg::FRAME_AW-1:
                                            pfba_pkg::FRAME_SHIFT+pfba_pkg::BIT_AW];
  assign in_range  = in_req_i.frame_address[pfba_pkg::ADDR_W-1:
                                            pfba_pkg::FRAME_SHIFT+pfba_pkg::FRAME_AW] == '0;
  assign out_take  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    res_d       = res_q;
    w_d         = w_q;
    bit_d       = bit_q;
    op_d        = op_q;
    vld_d       = vld_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = w_q;
    ram_wdata_o = word | bit_mask;
    ram_raddr_o = w_q + pfba_pkg::WORD_AW'(1);
    fin         = 1'b0;
    fin_res     = '{status: pfba_pkg::ST_OK, alloc_address: '0};

    unique case (state_q)
      S_IDLE: begin
        ram_raddr_o = idle_addr;
        if (in_valid_i) begin
          op_d  = in_req_i.opcode;
          w_d   = idle_addr;
          bit_d = in_req_i.frame_address[pfba_pkg::FRAME_SHIFT+pfba_pkg::BIT_AW-1:
                                         pfba_pkg::FRAME_SHIFT];
          case (in_req_i.opcode) inside
            pfba_pkg::OP_ALLOC: begin
              if (start_ok) begin
                state_d = S_SCAN;
              end else begin
                fin            = 1'b1;
                fin_res.status = pfba_pkg::ST_NOMEM;
              end
            end
            pfba_pkg::OP_FREE, pfba_pkg::OP_RESERVE: begin
              if (in_range) begin
                state_d = S_RMW;
              end else begin
                fin            = 1'b1;
                fin_res.status = pfba_pkg::ST_RANGE;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // read of the next word is already in flight
        if (found) begin
          ram_we_o              = 1'b1;
          vld_d[w_q]            = 1'b1;
          fin                   = 1'b1;
          fin_res.alloc_address = {{(pfba_pkg::ADDR_W - pfba_pkg::FRAME_AW -
                                     pfba_pkg::FRAME_SHIFT){1'b0}},
                                   w_q, found_bit, {pfba_pkg::FRAME_SHIFT{1'b0}}};
        end else if (w_q == stop_m1[pfba_pkg::FRAME_AW-1:pfba_pkg::BIT_AW]) begin
          fin            = 1'b1;
          fin_res.status = pfba_pkg::ST_NOMEM;
        end else begin
          w_d = w_q + pfba_pkg::WORD_AW'(1);
        end
      end
      S_RMW: begin
        ram_we_o    = 1'b1;
        vld_d[w_q]  = 1'b1;
        ram_wdata_o = (op_q == pfba_pkg::OP_RESERVE) ? (word | bit_mask) : (word & ~bit_mask);
        fin         = 1'b1;
      end
      S_HOLD: begin
        if (out_take) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_take) begin
        out_valid_d = 1'b1;
        out_d       = fin_res;
        state_d     = S_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    res_q <= res_d;
    w_q   <= w_d;
    bit_q <= bit_d;
    op_q  <= op_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule
`default_nettype wire

// ===== design/page_frame_bitmap_allocator_core.sv =====
// First-fit page frame allocator, one used bit per 4 KiB frame.
// Request channel (in_valid_i/in_ready_o/in_req_i): opcode allocate, free or
// reserve plus a frame byte address. Every request gives exactly one result on
// the response channel (out_valid_o/out_ready_i/out_res_o): a status and, for
// a successful allocate, the frame's byte address.
// Steps from request transfer to result valid:
//   - allocate: the request is taken, then 64-bit bitmap words are scanned;
//     the scan reads one word per cycle from the bitmap RAM, with the next
//     word's read issued while the current one is checked
//   - free / reserve in range: read, then modify and write back
//   - out-of-range free/reserve, empty scan window, unused opcode: result produced as the request is taken
// One request is in progress at a time; the next request is taken once the
// current result sits in the output register.
// A stalled receiver leaves the result in the output register; a second
// finished result waits in an internal hold slot and blocks new requests.
// Reset frees every frame at once through a per-word valid flag (no clearing
// pass) and loads first_frame = 256, frame_limit = 4096.
// Configuration writes (cfg_we_i) take effect at the next edge in any state;
// issue them only while no request is in progress.
`default_nettype none
module page_frame_bitmap_allocator_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [pfba_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire pfba_pkg::req_t                in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output pfba_pkg::res_t                     out_res_o
);

  pfba_pkg::cfg_t                   cfg_q, cfg_d;

  logic                             ram_we;
  logic [pfba_pkg::WORD_AW-1:0]     ram_waddr;
  logic [pfba_pkg::WORD_BITS-1:0]   ram_wdata;
  logic [pfba_pkg::WORD_AW-1:0]     ram_raddr;
  logic [pfba_pkg::WORD_BITS-1:0]   ram_rdata;

  // config register file
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        pfba_pkg::CFG_FIRST_FRAME: cfg_d.first_frame = cfg_data_i[pfba_pkg::FRAME_AW-1:0];
        pfba_pkg::CFG_FRAME_LIMIT: cfg_d.frame_limit = cfg_data_i[pfba_pkg::LIMIT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_frame <= pfba_pkg::FIRST_FRAME_RST;
      cfg_q.frame_limit <= pfba_pkg::FRAME_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // bitmap words
  pfba_ram #(
    .WIDTH(pfba_pkg::WORD_BITS),
    .DEPTH(pfba_pkg::WORDS)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // scan / read-modify-write sequencer and result register
  pfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

endmodule
`default_nettype wire
